// ===== src/sctab_pkg.sv =====
// sctab_pkg: shared types and constants for the sorted code table search block.
// Holds the command word passed from front to back, config view and state codes.
// No dependencies.
package sctab_pkg;

    localparam int MAX_ADDR_W = 16;
    localparam int MAX_CNT_W  = 17;
    localparam int SLOT_W     = 10;
    localparam int CODE_W     = 32;
    localparam int GLYPH_W    = 10;
    localparam int USED_W     = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_USED_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_GLYPH = 2'd1;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_LOOKUP = 1'b1
    } t_sctab_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_DONE
    } t_sctab_state;

    typedef struct packed {
        t_sctab_op               op;
        logic                    wr_en;
        logic [MAX_ADDR_W-1:0]   addr;
        logic [CODE_W-1:0]       code;
    } t_sctab_cmd;

    typedef struct packed {
        logic [MAX_CNT_W-1:0]    count;
        logic [GLYPH_W-1:0]      dflt;
    } t_sctab_cfg;

endpackage

// ===== src/sctab_front.sv =====
// sctab_front: input word acceptance, load/lookup classification and config registers.
// Produces command words for the queue and the saturated search count.
// Depends on sctab_pkg.
module sctab_front
    import sctab_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_kind,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [CODE_W-1:0]     i_code,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [USED_W-1:0]     i_cfg_data,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_sctab_cmd            o_cmd,
    output t_sctab_cfg            o_cfg
);

    logic [USED_W-1:0]  r_used_count;
    logic [GLYPH_W-1:0] r_default_glyph;
    logic [USED_W-1:0]  n_used_count;
    logic [GLYPH_W-1:0] n_default_glyph;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_q_full;
    assign o_push      = i_valid && !i_q_full;

    always_comb begin
        n_used_count    = r_used_count;
        n_default_glyph = r_default_glyph;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_USED_COUNT:    n_used_count    = i_cfg_data;
                CFG_DEFAULT_GLYPH: n_default_glyph = i_cfg_data[GLYPH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_count    <= '0;
            r_default_glyph <= '0;
        end else begin
            r_used_count    <= n_used_count;
            r_default_glyph <= n_default_glyph;
        end
    end

    always_comb begin
        o_cmd.op    = t_sctab_op'(i_kind);
        o_cmd.wr_en = (32'(i_slot) < 32'(TABLE_ENTRIES));
        o_cmd.addr  = MAX_ADDR_W'(i_slot);
        o_cmd.code  = i_code;
    end

    // count saturates at table depth
    always_comb begin
        if (32'(r_used_count) > 32'(TABLE_ENTRIES)) begin
            o_cfg.count = MAX_CNT_W'(TABLE_ENTRIES);
        end else begin
            o_cfg.count = MAX_CNT_W'(r_used_count);
        end
        o_cfg.dflt = r_default_glyph;
    end

endmodule

// ===== src/sctab_queue.sv =====
// sctab_queue: two-entry command queue between front and back.
// Depends on sctab_pkg.
module sctab_queue
    import sctab_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_sctab_cmd  i_cmd,
    input  logic        i_pop,
    output t_sctab_cmd  o_cmd,
    output logic        o_full,
    output logic        o_empty
);

    t_sctab_cmd  r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic        n_wptr;
    logic        n_rptr;
    logic [1:0]  n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = !r_wptr;
        end
        if (i_pop) begin
            n_rptr = !r_rptr;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== src/sctab_back.sv =====
// sctab_back: code table memory, binary search sequencer and result register.
// Pops command words, writes loads, searches lookups by probe, then compare.
// Depends on sctab_pkg.
module sctab_back
    import sctab_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_sctab_cfg          i_cfg,
    input  t_sctab_cmd          i_cmd,
    input  logic                i_cmd_avail,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [GLYPH_W-1:0]  o_glyph_num,
    output logic                o_found
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int NW = AW + 1;

    logic [CODE_W-1:0] r_table [TABLE_ENTRIES];
    logic [CODE_W-1:0] r_rdata;

    t_sctab_state       r_state;
    t_sctab_state       n_state;
    logic [NW-1:0]      r_lo;
    logic [NW-1:0]      n_lo;
    logic [NW-1:0]      r_hp1;
    logic [NW-1:0]      n_hp1;
    logic [AW-1:0]      r_mid;
    logic [AW-1:0]      n_mid;
    logic [CODE_W-1:0]  r_key;
    logic [CODE_W-1:0]  n_key;
    logic [GLYPH_W-1:0] r_res_glyph;
    logic [GLYPH_W-1:0] n_res_glyph;
    logic               r_res_found;
    logic               n_res_found;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [GLYPH_W-1:0] r_out_glyph;
    logic [GLYPH_W-1:0] n_out_glyph;
    logic               r_out_found;
    logic               n_out_found;

    logic [NW:0]        mid_sum;
    logic [NW-1:0]      mid;
    logic               wr_en;

    assign o_valid     = r_out_valid;
    assign o_glyph_num = r_out_glyph;
    assign o_found     = r_out_found;

    // floor((lo + hi) / 2) with hi = hp1 - 1
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hp1} - (NW+1)'(1);
    assign mid     = mid_sum[NW:1];

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hp1       = r_hp1;
        n_mid       = r_mid;
        n_key       = r_key;
        n_res_glyph = r_res_glyph;
        n_res_found = r_res_found;
        n_out_valid = r_out_valid;
        n_out_glyph = r_out_glyph;
        n_out_found = r_out_found;
        o_pop       = 1'b0;
        wr_en       = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_avail) begin
                    o_pop = 1'b1;
                    if (i_cmd.op == OP_LOOKUP) begin
                        n_lo    = '0;
                        n_hp1   = NW'(i_cfg.count);
                        n_key   = i_cmd.code;
                        n_state = ST_PROBE;
                    end else begin
                        wr_en = i_cmd.wr_en;
                    end
                end
            end
            ST_PROBE: begin
                if (r_lo < r_hp1) begin
                    n_mid   = mid[AW-1:0];
                    n_state = ST_CMP;
                end else begin
                    n_res_glyph = i_cfg.dflt;
                    n_res_found = 1'b0;
                    n_state     = ST_DONE;
                end
            end
            ST_CMP: begin
                if (r_key < r_rdata) begin
                    n_hp1   = {1'b0, r_mid};
                    n_state = ST_PROBE;
                end else if (r_key > r_rdata) begin
                    n_lo    = {1'b0, r_mid} + NW'(1);
                    n_state = ST_PROBE;
                end else begin
                    n_res_glyph = GLYPH_W'(r_mid);
                    n_res_found = 1'b1;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_glyph = r_res_glyph;
                    n_out_found = r_res_found;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hp1       <= n_hp1;
        r_mid       <= n_mid;
        r_key       <= n_key;
        r_res_glyph <= n_res_glyph;
        r_res_found <= n_res_found;
        r_out_glyph <= n_out_glyph;
        r_out_found <= n_out_found;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[i_cmd.addr[AW-1:0]] <= i_cmd.code;
        end
        r_rdata <= r_table[mid[AW-1:0]];
    end

endmodule

// ===== src/sorted_code_table_search.sv =====
// sorted_code_table_search: top level of the sorted code table search block.
// Instantiates sctab_front, sctab_queue and sctab_back; depends on sctab_pkg.
//
//   channel | valid       | ready       | word
//   --------+-------------+-------------+------------------------------------
//   input   | i_valid     | o_ready     | i_kind, i_slot, i_code
//   result  | o_valid     | i_ready     | o_glyph_num, o_found
//   config  | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// A load is written to the table in the same cycle as it leaves the queue.
// A lookup does a memory read, then a compare, for each probe of its binary
// search, and returns the default glyph when the range runs empty.
// Reset clears control and config only; table entries are undefined until loaded.
// A two-word queue keeps input accepted, until it fills, while the back end
// searches or the result register waits on i_ready.
module sorted_code_table_search
    import sctab_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_kind,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [CODE_W-1:0]     i_code,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [GLYPH_W-1:0]    o_glyph_num,
    output logic                  o_found,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [USED_W-1:0]     i_cfg_data
);

    t_sctab_cmd  push_cmd;
    t_sctab_cmd  head_cmd;
    t_sctab_cfg  cfg;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;

    sctab_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_slot      (i_slot),
        .i_code      (i_code),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_cfg       (cfg)
    );

    sctab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sctab_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (head_cmd),
        .i_cmd_avail (!q_empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_glyph_num (o_glyph_num),
        .o_found     (o_found)
    );

    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("back end popped an empty queue");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_full && q_empty))
        else $error("queue reports full and empty together");

    a_full_then_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full && !pop |=> q_full)
        else $error("queue lost a word while full");

    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid after reset");

endmodule

// ===== tb/tb_sorted_code_table_search.sv =====
// tb_sorted_code_table_search: self-checking testbench for the sorted code table search.
// Loads code tables, runs lookups with bursty input and a stalling receiver, and
// predicts each glyph number/found word in the testbench. Depends on sctab_pkg.
module tb_sorted_code_table_search
    import sctab_pkg::*;
;

    localparam int TABLE_ENTRIES = 1024;
    localparam int RANDOM_ITEMS  = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct packed {
        t_sctab_op          op;
        logic [SLOT_W-1:0]  slot;
        logic [CODE_W-1:0]  code;
    } t_table_word;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic               hit;
    } t_lookup_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_kind = 1'b0;
    logic [SLOT_W-1:0]    i_slot = '0;
    logic [CODE_W-1:0]    i_code = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [GLYPH_W-1:0]   o_glyph_num;
    logic                 o_found;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [USED_W-1:0]    i_cfg_data = '0;

    t_table_word    words_to_send[$];
    t_lookup_result expected_glyphs[$];

    logic [CODE_W-1:0]  model_codes[TABLE_ENTRIES];
    logic [USED_W-1:0]  model_used_count = '0;
    logic [GLYPH_W-1:0] model_default_glyph = '0;
    logic [CODE_W-1:0]  staged_codes[TABLE_ENTRIES];

    int          sent_items = 0;
    int          error_count = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          cycle_count = 0;
    logic [9:0]  stall_phase = '0;
    t_table_word next_word;

    sorted_code_table_search #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_kind(i_kind),
        .i_slot(i_slot),
        .i_code(i_code),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_glyph_num(o_glyph_num),
        .o_found(o_found),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // binary search over the leading used_count slots, midpoint rounded down
    function automatic t_lookup_result search_codes(logic [CODE_W-1:0] key);
        int lo;
        int hi;
        int mid;
        int n;
        t_lookup_result r;
        n = (model_used_count > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(model_used_count);
        lo = 0;
        hi = n - 1;
        r.glyph = model_default_glyph;
        r.hit = 1'b0;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key < model_codes[mid]) begin
                hi = mid - 1;
            end else if (key > model_codes[mid]) begin
                lo = mid + 1;
            end else begin
                r.glyph = GLYPH_W'(mid);
                r.hit = 1'b1;
                return r;
            end
        end
        return r;
    endfunction

    function automatic void send_load(logic [SLOT_W-1:0] slot, logic [CODE_W-1:0] code);
        words_to_send.push_back('{op: OP_LOAD, slot: slot, code: code});
        staged_codes[slot] = code;
        sent_items++;
    endfunction

    function automatic void send_lookup(logic [CODE_W-1:0] code);
        words_to_send.push_back('{op: OP_LOOKUP, slot: SLOT_W'($urandom), code: code});
        sent_items++;
    endfunction

    function automatic void fill_sorted(int count, logic [CODE_W-1:0] max_step, bit allow_dup);
        logic [CODE_W-1:0] c;
        c = $urandom_range(0, max_step);
        for (int s = 0; s < count; s++) begin
            if (s > 0)
                c = c + $urandom_range(allow_dup ? 0 : 1, max_step);
            send_load(SLOT_W'(s), c);
        end
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [USED_W-1:0] data);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_USED_COUNT)
            model_used_count = data;
        else if (idx == CFG_DEFAULT_GLYPH)
            model_default_glyph = data[GLYPH_W-1:0];
    endtask

    // wait until every word is sent and every result has come, then let loads finish
    task automatic drain(int extra_cycles);
        while (words_to_send.size() != 0 || i_valid || expected_glyphs.size() != 0)
            @(posedge i_clk);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    // input driver: bursts of words separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                if (i_kind == OP_LOOKUP)
                    expected_glyphs.push_back(search_codes(i_code));
                else
                    model_codes[i_slot] = i_code;
            end
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (words_to_send.size() != 0) begin
                next_word = words_to_send.pop_front();
                i_valid <= 1'b1;
                i_kind  <= next_word.op;
                i_slot  <= next_word.slot;
                i_code  <= next_word.code;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor with its own stall pattern
    always @(posedge i_clk) begin : monitor
        t_lookup_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 1'b1;
            case (stall_phase[9:8])
                2'd0: i_ready <= 1'b1;
                2'd1: i_ready <= ($urandom_range(0, 1) == 0);
                2'd2: i_ready <= ($urandom_range(0, 4) == 0);
                default: i_ready <= stall_phase[2];
            endcase
            if (o_valid && i_ready) begin
                if (expected_glyphs.size() == 0) begin
                    $error("unexpected word: glyph_num=%0d found=%0d",
                           o_glyph_num, o_found);
                    error_count++;
                end else begin
                    want = expected_glyphs.pop_front();
                    if (o_glyph_num !== want.glyph) begin
                        $error("glyph_num: expected %0d, got %0d", want.glyph, o_glyph_num);
                        error_count++;
                    end
                    if (o_found !== want.hit) begin
                        $error("found: expected %0d, got %0d", want.hit, o_found);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int span;
        int eff;
        int layout;
        int n_lookups;
        int pause_at;
        int sel;
        int k;
        int start_items;
        logic [CODE_W-1:0] max_step;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table after reset
        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_FFFF);
        drain(SETTLE_CYCLES);
        write_register(CFG_DEFAULT_GLYPH, 11'h7FF);
        send_lookup($urandom);

        // whole table, ascending, spanning the full code range
        fill_sorted(TABLE_ENTRIES, 32'hFFFF_FFFF / (TABLE_ENTRIES + 1), 1'b0);
        send_load(SLOT_W'(0), 32'h0000_0000);
        send_load(SLOT_W'(TABLE_ENTRIES - 1), 32'hFFFF_FFFF);
        drain(SETTLE_CYCLES);
        write_register(CFG_USED_COUNT, USED_W'(TABLE_ENTRIES));
        write_register(CFG_DEFAULT_GLYPH, 11'd0);
        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(staged_codes[511]);
        send_lookup(staged_codes[512]);
        send_lookup(staged_codes[300] + 1);
        send_lookup(staged_codes[1022] + 1);
        drain(0);
        send_lookup(staged_codes[1]);
        send_lookup(staged_codes[1] - 1);

        // count above table size saturates
        drain(SETTLE_CYCLES);
        write_register(CFG_USED_COUNT, 11'h7FF);
        write_register(CFG_DEFAULT_GLYPH, 11'd512);
        send_lookup(staged_codes[1023]);
        send_lookup(staged_codes[700]);
        send_lookup(staged_codes[700] + 1);

        drain(SETTLE_CYCLES);
        write_register(CFG_USED_COUNT, 11'd1);
        send_lookup(32'h0000_0000);
        send_lookup(staged_codes[1]);
        drain(SETTLE_CYCLES);
        write_register(CFG_USED_COUNT, 11'd2);
        send_lookup(staged_codes[1]);

        start_items = sent_items;
        while (sent_items - start_items < RANDOM_ITEMS) begin
            drain(SETTLE_CYCLES);
            sel = $urandom_range(0, 19);
            if (sel == 0)
                span = 0;
            else if (sel == 1)
                span = $urandom_range(0, 1) ? TABLE_ENTRIES
                                            : $urandom_range(TABLE_ENTRIES + 1, 2047);
            else if (sel <= 3)
                span = $urandom_range(33, TABLE_ENTRIES - 1);
            else
                span = $urandom_range(1, 32);
            write_register(CFG_USED_COUNT, USED_W'(span));
            case ($urandom_range(0, 3))
                0: write_register(CFG_DEFAULT_GLYPH, {1'($urandom), 10'd0});
                1: write_register(CFG_DEFAULT_GLYPH, {1'($urandom), 10'h3FF});
                default: write_register(CFG_DEFAULT_GLYPH, USED_W'($urandom));
            endcase
            eff = (span > TABLE_ENTRIES) ? TABLE_ENTRIES : span;

            layout = $urandom_range(0, 9);
            max_step = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4)
                                                   : 32'hFFFF_FFFF / (eff + 1);
            if (layout <= 6 && (eff <= 32 || layout == 0)) begin
                fill_sorted(eff, max_step, layout == 6);
            end else if (layout == 7 && eff <= 32) begin
                for (int s = 0; s < eff; s++)
                    send_load(SLOT_W'(s), $urandom);
            end

            n_lookups = $urandom_range(6, 40);
            pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n_lookups - 1) : -1;
            for (int j = 0; j < n_lookups; j++) begin
                if (j == pause_at)
                    drain(0);
                k = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
                case ($urandom_range(0, 11))
                    0, 1, 2, 3, 4: send_lookup(staged_codes[k]);
                    5: send_lookup(staged_codes[k] + 1);
                    6: send_lookup(staged_codes[k] - 1);
                    7: send_lookup($urandom);
                    8: send_lookup(32'h0000_0000);
                    9: send_lookup(32'hFFFF_FFFF);
                    10: send_load(SLOT_W'($urandom), $urandom);
                    default: send_load(SLOT_W'($urandom), staged_codes[k]);
                endcase
            end
        end

        drain(SETTLE_CYCLES);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sorted_code_table_search.f =====
src/sctab_pkg.sv
src/sctab_front.sv
src/sctab_queue.sv
src/sctab_back.sv
src/sorted_code_table_search.sv
tb/tb_sorted_code_table_search.sv
